// ===== sv/assert_macros.svh =====
// Assertion macros shared by the ray/box intersection RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RBSI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication after a fixed number of clock cycles.
`define RBSI_ASSERT_DELAY(label, clk, rst, n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("latency check failed");

`endif

// ===== sv/rbsi_pkg.sv =====
// Package for the ray/box slab intersection unit: widths, latencies,
// saturation limits and the per-axis slab result type. Depends on nothing.
package rbsi_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_AXES      = 3;

  // Divider: input register, setup stage, one stage per quotient bit, output.
  localparam int DIV_LAT   = WORD_W + 3;
  // Axis lane: difference stage, divider, ordering stage.
  localparam int LANE_LAT  = DIV_LAT + 2;
  // Merge: interval reduction stage, result stage.
  localparam int MERGE_LAT = 2;
  localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

  localparam logic signed [WORD_W-1:0] T_LOW  = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] T_HIGH = {1'b0, {(WORD_W-1){1'b1}}};

  typedef struct packed {
    logic                     par;    // direction component is zero
    logic                     pmiss;  // parallel axis with origin outside the slab
    logic signed [WORD_W-1:0] t_near;
    logic signed [WORD_W-1:0] t_far;
  } slab_t;

endpackage

// ===== sv/rbsi_div.sv =====
// Pipelined restoring divider with signed saturation to 32 bits.
// Depends on rbsi_pkg.
module rbsi_div #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic [rbsi_pkg::WORD_W+FRAC_BITS:0]      num_mag,
  input  logic [rbsi_pkg::WORD_W-1:0]              den_mag,
  input  logic                                     neg,
  output logic signed [rbsi_pkg::WORD_W-1:0]       quot
);
  import rbsi_pkg::*;

  localparam int NUM_W = WORD_W + 1 + FRAC_BITS;
  localparam int HI_W  = NUM_W - WORD_W;

  logic [NUM_W-1:0]  p_num;
  logic [WORD_W-1:0] p_den;
  logic              p_neg;
  logic [HI_W-1:0]   hi_part;
  logic              ovf0;

  logic [WORD_W-1:0] rem_q [0:WORD_W];
  logic [WORD_W-1:0] low_q [0:WORD_W];
  logic [WORD_W-1:0] quo_q [0:WORD_W];
  logic [WORD_W-1:0] den_q [0:WORD_W];
  logic              neg_q [0:WORD_W];
  logic              ovf_q [0:WORD_W];

  logic [WORD_W-1:0] q_fin;
  logic              sat_pos;
  logic              sat_neg;

  always_ff @(posedge clk) begin
    p_num <= num_mag;
    p_den <= den_mag;
    p_neg <= neg;
  end

  // The quotient fits 32 bits only when the upper numerator part is below the divisor.
  assign hi_part = p_num[NUM_W-1:WORD_W];
  assign ovf0    = ((2*WORD_W)'(hi_part) >= (2*WORD_W)'(p_den));

  always_ff @(posedge clk) begin
    rem_q[0] <= ovf0 ? '0 : WORD_W'(hi_part);
    low_q[0] <= p_num[WORD_W-1:0];
    quo_q[0] <= '0;
    den_q[0] <= p_den;
    neg_q[0] <= p_neg;
    ovf_q[0] <= ovf0;
  end

  for (genvar k = 0; k < WORD_W; k++) begin : g_step
    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;
    logic            ge;

    assign trial = {rem_q[k], low_q[k][WORD_W-1]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign ge    = (trial >= {1'b0, den_q[k]});

    always_ff @(posedge clk) begin
      rem_q[k+1] <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      low_q[k+1] <= {low_q[k][WORD_W-2:0], 1'b0};
      quo_q[k+1] <= {quo_q[k][WORD_W-2:0], ge};
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign q_fin   = quo_q[WORD_W];
  assign sat_pos = ovf_q[WORD_W] || q_fin[WORD_W-1];
  assign sat_neg = ovf_q[WORD_W] || (q_fin[WORD_W-1] && (|q_fin[WORD_W-2:0]));

  always_ff @(posedge clk) begin
    if (neg_q[WORD_W]) begin
      quot <= sat_neg ? T_LOW : $signed(-q_fin);
    end else begin
      quot <= sat_pos ? T_HIGH : $signed(q_fin);
    end
  end

endmodule

// ===== sv/rbsi_lane.sv =====
// One axis lane: slab differences, parallel test, two divisions, ordering.
// Depends on rbsi_pkg and rbsi_div.
module rbsi_lane #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic signed [rbsi_pkg::WORD_W-1:0]   org,
  input  logic signed [rbsi_pkg::WORD_W-1:0]   dir,
  input  logic signed [rbsi_pkg::WORD_W-1:0]   lo,
  input  logic signed [rbsi_pkg::WORD_W-1:0]   hi,
  output rbsi_pkg::slab_t                      slab
);
  import rbsi_pkg::*;

  localparam int NUM_W = WORD_W + 1 + FRAC_BITS;

  logic signed [WORD_W:0] far_d;
  logic signed [WORD_W:0] near_d;
  logic [WORD_W-1:0]      dmag;
  logic                   dneg;
  logic                   par_a;
  logic                   pmiss_a;

  logic [WORD_W:0]        far_mag;
  logic [WORD_W:0]        near_mag;
  logic signed [WORD_W-1:0] t1;
  logic signed [WORD_W-1:0] t2;

  logic par_q   [0:DIV_LAT-1];
  logic pmiss_q [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    far_d   <= (WORD_W+1)'(hi) - (WORD_W+1)'(org);
    near_d  <= (WORD_W+1)'(lo) - (WORD_W+1)'(org);
    dmag    <= dir[WORD_W-1] ? WORD_W'(-dir) : WORD_W'(dir);
    dneg    <= dir[WORD_W-1];
    par_a   <= (dir == '0);
    pmiss_a <= (dir == '0) &&
               (((WORD_W+1)'(hi) - (WORD_W+1)'(org) < 0) ||
                ((WORD_W+1)'(lo) - (WORD_W+1)'(org) > 0));
  end

  assign far_mag  = far_d[WORD_W]  ? (WORD_W+1)'(-far_d)  : (WORD_W+1)'(far_d);
  assign near_mag = near_d[WORD_W] ? (WORD_W+1)'(-near_d) : (WORD_W+1)'(near_d);

  rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_far (
    .clk     (clk),
    .num_mag ({far_mag, {FRAC_BITS{1'b0}}}),
    .den_mag (dmag),
    .neg     (far_d[WORD_W] ^ dneg),
    .quot    (t1)
  );

  rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_near (
    .clk     (clk),
    .num_mag (NUM_W'({near_mag, {FRAC_BITS{1'b0}}})),
    .den_mag (dmag),
    .neg     (near_d[WORD_W] ^ dneg),
    .quot    (t2)
  );

  always_ff @(posedge clk) begin
    par_q[0]   <= par_a;
    pmiss_q[0] <= pmiss_a;
    for (int i = 1; i < DIV_LAT; i++) begin
      par_q[i]   <= par_q[i-1];
      pmiss_q[i] <= pmiss_q[i-1];
    end
  end

  always_ff @(posedge clk) begin
    slab.par    <= par_q[DIV_LAT-1];
    slab.pmiss  <= pmiss_q[DIV_LAT-1];
    slab.t_near <= (t1 > t2) ? t2 : t1;
    slab.t_far  <= (t1 > t2) ? t1 : t2;
  end

endmodule

// ===== sv/rbsi_merge.sv =====
// Merge stage: intersects the three slab intervals and forms hit and distance.
// Depends on rbsi_pkg.
module rbsi_merge (
  input  logic                                clk,
  input  rbsi_pkg::slab_t                     slab [0:rbsi_pkg::NUM_AXES-1],
  output logic                                hit,
  output logic signed [rbsi_pkg::WORD_W-1:0]  hit_distance
);
  import rbsi_pkg::*;

  logic signed [WORD_W-1:0] lo_e [0:NUM_AXES-1];
  logic signed [WORD_W-1:0] hi_e [0:NUM_AXES-1];
  logic signed [WORD_W-1:0] t_in_c;
  logic signed [WORD_W-1:0] t_out_c;
  logic                     pm_c;
  logic signed [WORD_W-1:0] t_in;
  logic signed [WORD_W-1:0] t_out;
  logic                     pm;
  logic                     miss;

  // A parallel axis leaves the interval alone.
  always_comb begin
    t_in_c  = T_LOW;
    t_out_c = T_HIGH;
    pm_c    = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo_e[a] = slab[a].par ? T_LOW  : slab[a].t_near;
      hi_e[a] = slab[a].par ? T_HIGH : slab[a].t_far;
      if (lo_e[a] > t_in_c) begin
        t_in_c = lo_e[a];
      end
      if (hi_e[a] < t_out_c) begin
        t_out_c = hi_e[a];
      end
      pm_c = pm_c | slab[a].pmiss;
    end
  end

  always_ff @(posedge clk) begin
    t_in  <= t_in_c;
    t_out <= t_out_c;
    pm    <= pm_c;
  end

  assign miss = pm || (t_in > t_out) || (t_out < 0);

  always_ff @(posedge clk) begin
    hit          <= !miss;
    hit_distance <= miss ? '0 : ((t_in > 0) ? t_in : t_out);
  end

endmodule

// ===== sv/ray_box_slab_intersect_unit.sv =====
// Top level of the ray versus axis-aligned box slab intersection unit.
// Depends on rbsi_pkg, rbsi_lane, rbsi_merge and assert_macros.svh.
//
// A transaction is accepted on every clock edge where start is high and
// rst is low; busy is held low, so one ray/box test enters per cycle
// with no gaps. Each transaction produces exactly one result: done is
// high for a single cycle and hit and hit_distance are valid with it.
// The receiver cannot stall the unit, so it must capture every result in
// the cycle done is high. Most of the latency lies in the per-axis
// pipelined dividers, which resolve one quotient bit per stage. Three
// axis lanes run side by side, each with two dividers for the near and
// far slab planes, and a two-stage merge forms the entry/exit interval.
// On a miss hit is 0 and hit_distance is 0; on a hit the distance is the
// entry parameter when positive, else the exit parameter, saturated to
// the signed 32-bit range.
module ray_box_slab_intersect_unit #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  origin_x,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  origin_y,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  origin_z,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  dir_x,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  dir_y,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  dir_z,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  box_min_x,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  box_min_y,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  box_min_z,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  box_max_x,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  box_max_y,
  input  logic signed [rbsi_pkg::WORD_W-1:0]  box_max_z,
  output logic                                done,
  output logic                                hit,
  output logic signed [rbsi_pkg::WORD_W-1:0]  hit_distance
);
  import rbsi_pkg::*;
  `include "assert_macros.svh"

  logic signed [WORD_W-1:0] org_r [0:NUM_AXES-1];
  logic signed [WORD_W-1:0] dir_r [0:NUM_AXES-1];
  logic signed [WORD_W-1:0] lo_r  [0:NUM_AXES-1];
  logic signed [WORD_W-1:0] hi_r  [0:NUM_AXES-1];
  slab_t                    slab  [0:NUM_AXES-1];
  logic [PIPE_LAT:0]        vpipe;

  // The pipeline never stalls, so the unit is always ready.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    org_r[0] <= origin_x;   org_r[1] <= origin_y;   org_r[2] <= origin_z;
    dir_r[0] <= dir_x;      dir_r[1] <= dir_y;      dir_r[2] <= dir_z;
    lo_r[0]  <= box_min_x;  lo_r[1]  <= box_min_y;  lo_r[2]  <= box_min_z;
    hi_r[0]  <= box_max_x;  hi_r[1]  <= box_max_y;  hi_r[2]  <= box_max_z;
  end

  // Valid bits follow each transaction through the fixed-latency datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[PIPE_LAT-1:0], start && !busy};
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .org  (org_r[a]),
      .dir  (dir_r[a]),
      .lo   (lo_r[a]),
      .hi   (hi_r[a]),
      .slab (slab[a])
    );
  end

  rbsi_merge u_merge (
    .clk          (clk),
    .slab         (slab),
    .hit          (hit),
    .hit_distance (hit_distance)
  );

  assign done = vpipe[PIPE_LAT];

  // A miss always reports a zero distance.
  `RBSI_ASSERT_IMPLIES(a_miss_zero, clk, rst, done && !hit, hit_distance == '0)
  // A hit lies on the forward half of the ray.
  `RBSI_ASSERT_IMPLIES(a_hit_nonneg, clk, rst, done && hit, !hit_distance[WORD_W-1])
  // Every accepted transaction yields its result after the fixed latency.
  `RBSI_ASSERT_DELAY(a_latency, clk, rst, PIPE_LAT + 1, start && !busy, done)

endmodule
